// ===== src/edu_pkg.sv =====
// Shared types and constants for the Euclidean distance unit.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package edu_pkg;

  localparam int MAX_DIM_DEFAULT = 256;

  localparam int ELEM_W  = 16;
  localparam int SQ_W    = 2 * ELEM_W;
  localparam int SUM_W   = 40;
  localparam int DIST_W  = SUM_W / 2;
  localparam int CNT_W   = 9;
  localparam int CNT_MAX = (1 << CNT_W) - 1;

  // One result bit per root iteration.
  localparam int ROOT_STEPS = DIST_W;
  localparam int STEP_W     = $clog2(ROOT_STEPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_ROOT,
    ST_OUT
  } edu_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;       // capture request, form |a - b|
    logic square;     // square the magnitude
    logic accum;      // add to the running sum, count the pair
    logic root_step;  // one iteration of the square root
    logic publish;    // move the finished result into the output register
  } edu_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic last;       // captured request closes the vector
    logic root_done;  // final root iteration is under way
  } edu_status_t;

endpackage

`default_nettype wire

// ===== src/edu_in_if.sv =====
// Input channel: one component pair per request, valid/ready handshake.
// Depends on edu_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface edu_in_if
  import edu_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] elem_a;
  logic signed [ELEM_W-1:0] elem_b;
  logic                     last;

  modport source (output valid, output elem_a, output elem_b, output last, input ready);
  modport sink   (input valid, input elem_a, input elem_b, input last, output ready);
endinterface

`default_nettype wire

// ===== src/edu_out_if.sv =====
// Result channel: one distance result per vector, valid/ready handshake.
// Depends on edu_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface edu_out_if
  import edu_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [SUM_W-1:0]  squared_distance;
  logic [DIST_W-1:0] distance;
  logic [CNT_W-1:0]  element_count;
  logic              overflow;

  modport source (output valid, output squared_distance, output distance,
                  output element_count, output overflow, input ready);
  modport sink   (input valid, input squared_distance, input distance,
                  input element_count, input overflow, output ready);
endinterface

`default_nettype wire

// ===== src/edu_ctrl.sv =====
// Sequencer for the Euclidean distance unit: handshakes and datapath commands.
// Depends on edu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module edu_ctrl
  import edu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  input  wire edu_status_t status,
  output edu_cmd_t         cmd
);

  edu_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd.accum = 1'b1;
        state_nxt = status.last ? ST_ROOT : ST_IDLE;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (status.root_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        // wait here only while the output register still holds an untaken result
        if (!out_valid_r || out_ready) begin
          cmd.publish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== src/edu_dp.sv =====
// Datapath: difference, square, saturating accumulate, bitwise square root.
// Depends on edu_pkg; driven by edu_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module edu_dp
  import edu_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire edu_cmd_t                 cmd,
  output edu_status_t                   status,
  input  wire logic signed [ELEM_W-1:0] elem_a,
  input  wire logic signed [ELEM_W-1:0] elem_b,
  input  wire logic                     last,
  output logic [SUM_W-1:0]              squared_distance,
  output logic [DIST_W-1:0]             distance,
  output logic [CNT_W-1:0]              element_count,
  output logic                          overflow
);

  // Count stops at the smaller of MAX_DIM and the counter's range.
  localparam int CntCapInt = (MAX_DIM < CNT_MAX) ? MAX_DIM : CNT_MAX;
  localparam logic [CNT_W-1:0] CntCap = CntCapInt[CNT_W-1:0];
  // Only when the cap is MAX_DIM itself does an extra pair mean overflow.
  localparam logic CapIsDim = (MAX_DIM <= CNT_MAX);
  localparam logic [STEP_W-1:0] LastStep = STEP_W'(ROOT_STEPS - 1);

  logic [ELEM_W-1:0] mag_r;
  logic              last_r;
  logic [SQ_W-1:0]   sq_r;

  logic [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              ovf_r;

  logic [SUM_W-1:0]  res_sum_r;
  logic [CNT_W-1:0]  res_cnt_r;
  logic              res_ovf_r;

  logic [SUM_W-1:0]  op_r;
  logic [DIST_W:0]   rem_r;
  logic [DIST_W-1:0] root_r;
  logic [STEP_W-1:0] step_r;

  // Output register: holds the result while the receiver stalls.
  logic [SUM_W-1:0]  out_sum_r;
  logic [DIST_W-1:0] out_dist_r;
  logic [CNT_W-1:0]  out_cnt_r;
  logic              out_ovf_r;

  // |a - b| fits in ELEM_W bits unsigned.
  logic signed [ELEM_W:0] diff;
  logic [ELEM_W:0]        diff_abs;

  logic [SUM_W:0]    sum_ext;
  logic [SUM_W-1:0]  sum_sat;
  logic [SUM_W-1:0]  sum_nxt;
  logic [CNT_W-1:0]  cnt_nxt;
  logic              ovf_nxt;
  logic              at_cap;

  logic [DIST_W+2:0] rem_sh;
  logic [DIST_W+2:0] trial;
  logic [DIST_W+2:0] rem_sub;
  logic              take;

  always_comb begin
    diff     = {elem_a[ELEM_W-1], elem_a} - {elem_b[ELEM_W-1], elem_b};
    diff_abs = diff[ELEM_W] ? (~diff + 1'b1) : diff;
  end

  always_comb begin
    sum_ext = {1'b0, sum_r} + {{(SUM_W + 1 - SQ_W){1'b0}}, sq_r};
    sum_sat = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
    at_cap  = (cnt_r >= CntCap);
    sum_nxt = sum_sat;
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (at_cap) begin
      if (CapIsDim) begin
        sum_nxt = {SUM_W{1'b1}};
        ovf_nxt = 1'b1;
      end
    end else begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  // Root iteration: bring down two operand bits, try (root << 2) | 1.
  always_comb begin
    rem_sh  = {rem_r, op_r[SUM_W-1 -: 2]};
    trial   = {1'b0, root_r, 2'b01};
    rem_sub = rem_sh - trial;
    take    = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r  <= diff_abs[ELEM_W-1:0];
      last_r <= last;
    end
    if (cmd.square) begin
      sq_r <= mag_r * mag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (cmd.accum) begin
      if (last_r) begin
        sum_r <= '0;
        cnt_r <= '0;
        ovf_r <= 1'b0;
      end else begin
        sum_r <= sum_nxt;
        cnt_r <= cnt_nxt;
        ovf_r <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accum && last_r) begin
      res_sum_r <= sum_nxt;
      res_cnt_r <= cnt_nxt;
      res_ovf_r <= ovf_nxt;
      op_r      <= sum_nxt;
      rem_r     <= '0;
      root_r    <= '0;
      step_r    <= LastStep;
    end else if (cmd.root_step) begin
      op_r   <= {op_r[SUM_W-3:0], 2'b00};
      rem_r  <= take ? rem_sub[DIST_W:0] : rem_sh[DIST_W:0];
      root_r <= {root_r[DIST_W-2:0], take};
      step_r <= step_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_sum_r  <= res_sum_r;
      out_dist_r <= root_r;
      out_cnt_r  <= res_cnt_r;
      out_ovf_r  <= res_ovf_r;
    end
  end

  always_comb begin
    status.last      = last_r;
    status.root_done = (step_r == '0);
  end

  assign squared_distance = out_sum_r;
  assign distance         = out_dist_r;
  assign element_count    = out_cnt_r;
  assign overflow         = out_ovf_r;

endmodule

`default_nettype wire

// ===== src/euclidean_distance_unit_core.sv =====
// Top level of the Euclidean distance unit: sequencer plus datapath.
// Depends on edu_pkg, edu_in_if, edu_out_if, edu_ctrl and edu_dp.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   in_ch  : one request per component pair, signed Q8.8 elem_a / elem_b,
//            last high on the final pair of the two vectors.
//   out_ch : one result per vector: squared_distance (Q24.16, saturating at
//            all ones), distance = floor sqrt (Q12.8), element_count and the
//            overflow flag (more than MAX_DIM pairs seen, when MAX_DIM <= CNT_MAX).
// Timing
//   A pair passes through capture of |a - b|, square (16x16 multiplier) and a
//   saturating 40-bit add. in_ch.ready is high only between pairs.
//   On the last pair the square root follows, one result bit per cycle for
//   the 20-bit distance; the result then moves into the output register once
//   that register is free, which raises out_ch.valid.
// Stall
//   The result waits in the output register with out_ch.valid high until
//   out_ch.ready; meanwhile the next vector is taken. The input stalls only
//   once that vector's result is ready and the register is still full.
// Reset
//   rst_n (synchronous, active low) clears the sum, the count, the overflow
//   flag and the sequencer; no result is pending afterwards.

module euclidean_distance_unit_core
  import edu_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  edu_in_if.sink     in_ch,
  edu_out_if.source  out_ch
);

  edu_cmd_t    cmd;
  edu_status_t status;
  logic        in_ready;
  logic        out_valid;

  edu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  edu_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .elem_a           (in_ch.elem_a),
    .elem_b           (in_ch.elem_b),
    .last             (in_ch.last),
    .squared_distance (out_ch.squared_distance),
    .distance         (out_ch.distance),
    .element_count    (out_ch.element_count),
    .overflow         (out_ch.overflow)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  // Checks

  // A stalled result stays put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ch.ready) |=>
      (out_valid && $stable(out_ch.squared_distance) && $stable(out_ch.distance) &&
       $stable(out_ch.element_count) && $stable(out_ch.overflow)))
    else $error("pending result changed before it was taken");

  // Root bounds: d*d <= s < (d+1)*(d+1).
  a_root_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({{(SUM_W - DIST_W){1'b0}}, out_ch.distance} *
                   {{(SUM_W - DIST_W){1'b0}}, out_ch.distance}
                   <= out_ch.squared_distance))
    else $error("distance too large for squared distance");

  a_root_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (({{(SUM_W + 1 - DIST_W){1'b0}}, out_ch.distance} + 1'b1) *
                   ({{(SUM_W + 1 - DIST_W){1'b0}}, out_ch.distance} + 1'b1)
                   > {1'b0, out_ch.squared_distance}))
    else $error("distance too small for squared distance");

endmodule

`default_nettype wire
